// ----- src/pf_pkg.sv -----
// Shared constants, types and helpers for the Playfair digram encryptor.
package pf_pkg;

	localparam int LETTER_W = 5;
	localparam int NUM_LETTERS = 26;
	localparam int SIDE = 5;
	localparam int KEY_DEPTH = 40;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
	localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

	localparam logic OP_KEY = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} cell_t;

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		logic [2:0] r;
		if (v == 3'(SIDE - 1)) begin
			r = 3'd0;
		end else begin
			r = v + 3'd1;
		end
		return r;
	endfunction

endpackage

// ----- src/pf_in_if.sv -----
// Request channel carrying keyword and plaintext letters.
interface pf_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [pf_pkg::LETTER_W-1:0] letter;
	logic last;

	modport source (output valid, output operation, output letter, output last, input ready);
	modport sink (input valid, input operation, input letter, input last, output ready);
endinterface

// ----- src/pf_out_if.sv -----
// Request channel carrying encrypted letter pairs.
interface pf_out_if;
	logic valid;
	logic ready;
	logic [pf_pkg::LETTER_W-1:0] cipher_first;
	logic [pf_pkg::LETTER_W-1:0] cipher_second;
	logic message_end;

	modport source (output valid, output cipher_first, output cipher_second,
		output message_end, input ready);
	modport sink (input valid, input cipher_first, input cipher_second,
		input message_end, output ready);
endinterface

// ----- src/playfair_digram_encrypt.sv -----
// Playfair digram encryptor: key square build, digram pairing and cipher lookup.
//
// Channels: item (sink) takes one letter per request, operation 0 for a keyword
// letter and 1 for a plaintext letter, last marking the end of keyword or message.
// pair (source) delivers one ciphertext pair per request, message_end on the final
// pair. Both use a valid/ready handshake.
// Sequencing: the last keyword letter starts a fill walk over the alphabet. A
// plaintext letter that completes a pair passes through the states PA, PB, CALC,
// K2 and EMIT until the pair sits in the output register; a letter that yields
// two pairs runs that sequence twice. A letter that only gets held returns to idle
// at once. The sequencer shares one read port on the position table and one on the
// key square for every lookup. item.ready is high only while the sequencer idles.
// Reset clears the square-ready flag, the held letter and the sequencer; the
// tables need no clearing since they are read only once a square is complete.
// A stalled receiver holds the pair in the output register; the block keeps
// taking letters and waits only when a new pair must replace an untaken one.
module playfair_digram_encrypt (
	input logic clk,
	input logic arst_n,
	pf_in_if.sink item,
	pf_out_if.source pair
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_FILL = 7'b0000010,
		ST_PA = 7'b0000100,
		ST_PB = 7'b0001000,
		ST_CALC = 7'b0010000,
		ST_K2 = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [5:0] pos_mem [0:pf_pkg::NUM_LETTERS-1];
	pf_pkg::letter_t key_mem [0:pf_pkg::KEY_DEPTH-1];
	pf_pkg::cell_t pos_rd_q;
	pf_pkg::letter_t key_rd_q;
	logic [4:0] pos_raddr;
	logic [5:0] key_raddr;

	logic [pf_pkg::NUM_LETTERS-1:0] used_q;
	logic [pf_pkg::NUM_LETTERS-1:0] used_eff;
	logic [31:0] used_ext;
	pf_pkg::cell_t fill_q;
	pf_pkg::cell_t fill_eff;
	logic full_eff;
	logic [4:0] walk_q;
	logic square_ready_q;
	pf_pkg::letter_t held_q;
	logic held_valid_q;

	pf_pkg::letter_t p_a_q;
	pf_pkg::letter_t p_b_q;
	logic p_end_q;
	logic two_q;
	pf_pkg::letter_t sec_a_q;
	pf_pkg::cell_t pos_a_q;
	pf_pkg::cell_t n1;
	pf_pkg::cell_t n2;
	pf_pkg::cell_t n2_q;
	pf_pkg::letter_t k1_q;

	logic out_valid_q;
	pf_pkg::letter_t out_first_q;
	pf_pkg::letter_t out_second_q;
	logic out_end_q;

	logic accept;
	logic place_en;
	pf_pkg::letter_t place_letter;
	pf_pkg::letter_t text_letter;
	logic load_out;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || pair.ready);

	assign pair.valid = out_valid_q;
	assign pair.cipher_first = out_first_q;
	assign pair.cipher_second = out_second_q;
	assign pair.message_end = out_end_q;

	// a fresh keyword after a finished square starts from an empty square
	always_comb begin
		if (state_q == ST_IDLE && square_ready_q) begin
			used_eff = '0;
			fill_eff = '0;
		end else begin
			used_eff = used_q;
			fill_eff = fill_q;
		end
	end

	assign used_ext = {6'd0, used_eff};
	assign full_eff = (fill_eff.row == 3'(pf_pkg::SIDE));
	assign text_letter = (item.letter == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : item.letter;

	always_comb begin
		place_en = 1'b0;
		place_letter = item.letter;
		if (state_q == ST_IDLE && accept && item.operation == pf_pkg::OP_KEY) begin
			place_letter = item.letter;
			place_en = (item.letter <= pf_pkg::LETTER_Z) && (item.letter != pf_pkg::LETTER_J)
				&& !used_ext[item.letter] && !full_eff;
		end else if (state_q == ST_FILL) begin
			place_letter = walk_q;
			place_en = (walk_q != pf_pkg::LETTER_J) && !used_ext[walk_q] && !full_eff;
		end
	end

	always_comb begin
		if (pos_a_q.row == pos_rd_q.row) begin
			n1 = '{row: pos_a_q.row, col: pf_pkg::wrap_inc(pos_a_q.col)};
			n2 = '{row: pos_rd_q.row, col: pf_pkg::wrap_inc(pos_rd_q.col)};
		end else if (pos_a_q.col == pos_rd_q.col) begin
			n1 = '{row: pf_pkg::wrap_inc(pos_a_q.row), col: pos_a_q.col};
			n2 = '{row: pf_pkg::wrap_inc(pos_rd_q.row), col: pos_rd_q.col};
		end else begin
			n1 = '{row: pos_a_q.row, col: pos_rd_q.col};
			n2 = '{row: pos_rd_q.row, col: pos_a_q.col};
		end
	end

	assign pos_raddr = (state_q == ST_PA) ? p_a_q : p_b_q;
	assign key_raddr = (state_q == ST_CALC) ? 6'(n1) : 6'(n2_q);

	always_ff @(posedge clk) begin
		if (place_en) begin
			key_mem[6'(fill_eff)] <= place_letter;
			pos_mem[place_letter] <= 6'(fill_eff);
		end
		pos_rd_q <= pf_pkg::cell_t'(pos_mem[pos_raddr]);
		key_rd_q <= key_mem[key_raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.operation == pf_pkg::OP_KEY && item.last) begin
					state_d = ST_FILL;
				end else if (accept && item.operation == pf_pkg::OP_TEXT && square_ready_q) begin
					if (item.letter > pf_pkg::LETTER_Z) begin
						if (item.last && held_valid_q) begin
							state_d = ST_PA;
						end
					end else if (held_valid_q || item.last) begin
						state_d = ST_PA;
					end
				end
			end
			ST_FILL: begin
				if (walk_q == pf_pkg::LETTER_Z) begin
					state_d = ST_IDLE;
				end
			end
			ST_PA: state_d = ST_PB;
			ST_PB: state_d = ST_CALC;
			ST_CALC: state_d = ST_K2;
			ST_K2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (load_out) begin
					state_d = two_q ? ST_PA : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			fill_q <= '0;
			walk_q <= '0;
			square_ready_q <= 1'b0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			two_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (place_en) begin
				used_q <= used_eff | (pf_pkg::NUM_LETTERS'(1) << place_letter);
				if (fill_eff.col == 3'(pf_pkg::SIDE - 1)) begin
					fill_q <= '{row: fill_eff.row + 3'd1, col: 3'd0};
				end else begin
					fill_q <= '{row: fill_eff.row, col: fill_eff.col + 3'd1};
				end
			end else begin
				used_q <= used_eff;
				fill_q <= fill_eff;
			end
			if (state_q == ST_IDLE && accept && item.operation == pf_pkg::OP_KEY) begin
				if (square_ready_q) begin
					square_ready_q <= 1'b0;
					held_valid_q <= 1'b0;
				end
				walk_q <= '0;
			end
			if (state_q == ST_FILL) begin
				walk_q <= walk_q + 5'd1;
				if (walk_q == pf_pkg::LETTER_Z) begin
					square_ready_q <= 1'b1;
				end
			end
			if (state_q == ST_IDLE && accept && item.operation == pf_pkg::OP_TEXT
				&& square_ready_q) begin
				if (item.letter > pf_pkg::LETTER_Z) begin
					if (item.last) begin
						held_valid_q <= 1'b0;
					end
					two_q <= 1'b0;
				end else if (held_valid_q) begin
					held_q <= text_letter;
					held_valid_q <= (held_q == text_letter) && !item.last;
					two_q <= (held_q == text_letter) && item.last;
				end else begin
					held_q <= text_letter;
					held_valid_q <= !item.last;
					two_q <= 1'b0;
				end
			end
			if (state_q == ST_EMIT && load_out) begin
				two_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pair.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pair operands, lookup results and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			sec_a_q <= text_letter;
			if (item.letter > pf_pkg::LETTER_Z) begin
				p_a_q <= held_q;
				p_b_q <= pf_pkg::LETTER_Z;
				p_end_q <= 1'b1;
			end else if (held_valid_q) begin
				p_a_q <= held_q;
				if (held_q == text_letter) begin
					p_b_q <= pf_pkg::LETTER_X;
					p_end_q <= 1'b0;
				end else begin
					p_b_q <= text_letter;
					p_end_q <= item.last;
				end
			end else begin
				p_a_q <= text_letter;
				p_b_q <= pf_pkg::LETTER_Z;
				p_end_q <= 1'b1;
			end
		end
		if (state_q == ST_EMIT && load_out && two_q) begin
			p_a_q <= sec_a_q;
			p_b_q <= pf_pkg::LETTER_Z;
			p_end_q <= 1'b1;
		end
		if (state_q == ST_PB) begin
			pos_a_q <= pos_rd_q;
		end
		if (state_q == ST_CALC) begin
			n2_q <= n2;
		end
		if (state_q == ST_K2) begin
			k1_q <= key_rd_q;
		end
		if (load_out) begin
			out_first_q <= k1_q;
			out_second_q <= key_rd_q;
			out_end_q <= p_end_q;
		end
	end

endmodule
